// ----- rtl/bpfs_pkg.sv -----
package bpfs_pkg;

  // Stack geometry. Entries are indexed with just enough bits for the depth.
  localparam int STACK_DEPTH = 1024;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Field widths.
  localparam int CNT_W  = 11;
  localparam int ADDR_W = 64;
  localparam int SIZE_W = 16;
  localparam int BLK_W  = SIZE_W + 1;

  // Configuration port geometry: four registers at a stride of eight bytes.
  localparam int REG_IDX_W = 2;
  localparam int PADDR_W   = REG_IDX_W + 3;
  localparam int PDATA_W   = 64;

  localparam logic [REG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALIGN = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_NBUF  = 2'd3;

  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_GET  = 2'd1;
  localparam logic [1:0] CMD_PUT  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DEPLETED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] region_base;
    logic [SIZE_W-1:0] buffer_size;
    logic [SIZE_W-1:0] buffer_alignment;
    logic [CNT_W-1:0]  num_buffers;
  } cfg_t;

endpackage

// ----- rtl/bpfs_cfg_regs.sv -----
module bpfs_cfg_regs import bpfs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [REG_IDX_W-1:0] reg_sel;
  logic                 wr_fire;

  assign reg_sel = paddr[PADDR_W-1:3];
  assign wr_fire = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.region_base      <= '0;
      cfg.buffer_size      <= SIZE_W'(64);
      cfg.buffer_alignment <= SIZE_W'(8);
      cfg.num_buffers      <= '0;
    end else if (wr_fire) begin
      case (reg_sel)
        REG_BASE:  cfg.region_base      <= pwdata;
        REG_SIZE:  cfg.buffer_size      <= pwdata[SIZE_W-1:0];
        REG_ALIGN: cfg.buffer_alignment <= pwdata[SIZE_W-1:0];
        REG_NBUF:  cfg.num_buffers      <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BASE:  prdata = cfg.region_base;
      REG_SIZE:  prdata = PDATA_W'(cfg.buffer_size);
      REG_ALIGN: prdata = PDATA_W'(cfg.buffer_alignment);
      REG_NBUF:  prdata = PDATA_W'(cfg.num_buffers);
      default:   prdata = '0;
    endcase
  end

endmodule

// ----- rtl/bpfs_rem_div.sv -----
module bpfs_rem_div import bpfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [SIZE_W-1:0] remainder
);

  localparam int DCNT_W = $clog2(ADDR_W + 1);

  logic [ADDR_W-1:0] dvd;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dsr;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic [SIZE_W-1:0] rem_next;

  // Restoring division, one dividend bit per cycle; only the remainder is kept.
  always_comb begin
    trial    = {rem, dvd[ADDR_W-1]};
    diff     = trial - {1'b0, dsr};
    rem_next = (trial >= {1'b0, dsr}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(ADDR_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[ADDR_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

// ----- rtl/bpfs_stack_ram.sv -----
module bpfs_stack_ram import bpfs_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [ADDR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [ADDR_W-1:0] rd_data
);

  logic [ADDR_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/buffer_pool_free_stack.sv -----
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+--------------------------------------
// in       | input     | in_valid / in_ready    | cmd, freed_address
// out      | output    | out_valid / out_ready  | status, granted_address, buffers_in_use
// cfg      | input     | APB psel/penable/pready| paddr, pwdata, prdata
//
// Put, depleted get and the unused command go from transfer in through S_DONE to the
// output register; a successful get first passes S_GET, which takes the stack RAM read.
// Init runs two 64-step remainder computations on the shared serial divider, then
// one stack RAM write per buffer.
// A new command is taken while the previous result still waits in the output register.
// Reset is synchronous and clears the counters and handshake state; the stack RAM is
// not cleared, since pool bookkeeping never reads an entry before it is written.
module buffer_pool_free_stack import bpfs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Command channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [ADDR_W-1:0]  freed_address,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [ADDR_W-1:0]  granted_address,
  output logic [CNT_W-1:0]   buffers_in_use,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM_BASE,
    S_REM_SIZE,
    S_FILL,
    S_GET,
    S_DONE
  } state_t;

  state_t state;
  cfg_t   cfg;

  // Pool bookkeeping.
  logic [CNT_W-1:0]  top_index;
  logic [CNT_W-1:0]  pool_count;

  // Init walk.
  logic [CNT_W-1:0]  fill_idx;
  logic [ADDR_W-1:0] fill_addr;
  logic [BLK_W-1:0]  blk;

  // Result waiting for the output register.
  logic [1:0]        pend_status;
  logic [ADDR_W-1:0] pend_granted;

  logic              in_fire;
  logic              out_free;
  logic              get_ok;
  logic              put_ok;
  logic              fill_wr;
  logic [SIZE_W-1:0] eff_align;
  logic [SIZE_W-1:0] pad;
  logic [CNT_W-1:0]  sat_count;

  logic              div_start;
  logic [ADDR_W-1:0] div_dividend;
  logic              div_done;
  logic [SIZE_W-1:0] div_rem;

  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [ADDR_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_data;

  bpfs_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpfs_rem_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (eff_align),
    .done      (div_done),
    .remainder (div_rem)
  );

  bpfs_stack_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (top_index[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // A zero alignment behaves as an alignment of one.
  assign eff_align = (cfg.buffer_alignment == '0) ? SIZE_W'(1) : cfg.buffer_alignment;

  // Distance up to the next multiple of the alignment, from the divider's remainder.
  assign pad = (div_rem == '0) ? '0 : eff_align - div_rem;

  assign sat_count = (cfg.num_buffers > CNT_W'(STACK_DEPTH)) ? CNT_W'(STACK_DEPTH)
                                                             : cfg.num_buffers;

  assign get_ok  = (cmd == CMD_GET) && (top_index < pool_count)
                   && (top_index < CNT_W'(STACK_DEPTH));
  assign put_ok  = (cmd == CMD_PUT) && (top_index != '0);
  assign fill_wr = (state == S_FILL) && (fill_idx < pool_count);

  assign ram_rd_en = in_fire && get_ok;

  // The base remainder runs first, then the buffer size remainder.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = cfg.region_base;
    if (in_fire && (cmd == CMD_INIT)) begin
      div_start = 1'b1;
    end else if ((state == S_REM_BASE) && div_done) begin
      div_start    = 1'b1;
      div_dividend = ADDR_W'(cfg.buffer_size);
    end
  end

  // Stack RAM writes come either from a put or from the init walk, never both.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = fill_idx[IDX_W-1:0];
    ram_wr_data = fill_addr;
    if (fill_wr) begin
      ram_wr_en = 1'b1;
    end else if (in_fire && put_ok) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = IDX_W'(top_index - 1'b1);
      ram_wr_data = freed_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      top_index  <= '0;
      pool_count <= '0;
      fill_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      // In S_DONE a leaving result is directly replaced by the next one.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            pend_granted <= '0;
            case (cmd)
              CMD_INIT: begin
                pend_status <= ST_OK;
                state       <= S_REM_BASE;
              end
              CMD_GET: begin
                if (get_ok) begin
                  pend_status <= ST_OK;
                  top_index   <= top_index + 1'b1;
                  state       <= S_GET;
                end else begin
                  pend_status <= ST_DEPLETED;
                  state       <= S_DONE;
                end
              end
              CMD_PUT: begin
                if (put_ok) begin
                  pend_status <= ST_OK;
                  top_index   <= top_index - 1'b1;
                end else begin
                  pend_status <= ST_EMPTY;
                end
                state <= S_DONE;
              end
              default: begin
                pend_status <= ST_OK;
                state       <= S_DONE;
              end
            endcase
          end
        end
        S_REM_BASE: begin
          if (div_done) begin
            fill_addr <= cfg.region_base + ADDR_W'(pad);
            state     <= S_REM_SIZE;
          end
        end
        S_REM_SIZE: begin
          if (div_done) begin
            if (cfg.buffer_size < eff_align) begin
              blk <= BLK_W'(eff_align);
            end else begin
              blk <= BLK_W'(cfg.buffer_size) + BLK_W'(pad);
            end
            pool_count <= sat_count;
            fill_idx   <= '0;
            state      <= S_FILL;
          end
        end
        S_FILL: begin
          if (fill_wr) begin
            fill_idx  <= fill_idx + 1'b1;
            fill_addr <= fill_addr + ADDR_W'(blk);
          end else begin
            top_index <= '0;
            state     <= S_DONE;
          end
        end
        S_GET: begin
          pend_granted <= ram_rd_data;
          state        <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            status          <= pend_status;
            granted_address <= pend_granted;
            buffers_in_use  <= top_index;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
